>>> rtl/dsdr_pkg.sv
// Shared types, register indexes, zone codes and widths for the differential relay.
// No dependencies.
`timescale 1ns / 1ps

package dsdr_pkg;

    localparam int PH_W    = 17;                 // phasor component incl. sum of two terminals
    localparam int SQ_W    = 34;                 // re^2 + im^2
    localparam int RAD_W   = SQ_W + 16;          // radicand, magnitude in Q8 after sqrt
    localparam int ROOT_W  = RAD_W / 2;          // magnitude width
    localparam int REM_W   = ROOT_W + 1;
    localparam int NUM_W   = ROOT_W + 1;         // m1 + m2
    localparam int DEN_W   = 16;
    localparam int LAT     = 1 + ROOT_W + 1 + NUM_W + 2;

    localparam logic [15:0] SLOPE_DEN = 16'd25600;
    localparam logic signed [31:0] BRK_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] BRK_MIN = 32'sh8000_0000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICKUP_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PICKUP_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HIGH   = 3'd6;

    localparam logic [2:0] ZONE_NONE     = 3'd0;
    localparam logic [2:0] ZONE_PICKUP_L = 3'd1;
    localparam logic [2:0] ZONE_SLOPE_1  = 3'd2;
    localparam logic [2:0] ZONE_SLOPE_2  = 3'd3;
    localparam logic [2:0] ZONE_PICKUP_H = 3'd4;

    typedef struct packed {
        logic signed [15:0] first_real;
        logic signed [15:0] first_imag;
        logic signed [15:0] second_real;
        logic signed [15:0] second_imag;
    } in_item_t;

    typedef struct packed {
        logic        trip;
        logic [2:0]  zone;
        logic [15:0] restraint;
        logic [15:0] operate;
    } out_item_t;

    typedef struct packed {
        logic [15:0] nominal_current;
        logic [15:0] pickup_low;
        logic [15:0] pickup_high;
        logic [15:0] slope_low_pct;
        logic [15:0] slope_high_pct;
        logic [15:0] base_low;
        logic [15:0] base_high;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        nominal_current: 16'd256,
        pickup_low:      16'd77,
        pickup_high:     16'd2560,
        slope_low_pct:   16'd6400,
        slope_high_pct:  16'd20480,
        base_low:        16'd0,
        base_high:       16'd512
    };

    typedef struct packed {
        logic               busy;
        logic signed [31:0] brk1;
        logic signed [31:0] brk2;
        logic signed [31:0] brk3;
    } brk_t;

endpackage

>>> rtl/dsdr_sqrt.sv
// Pipelined magnitude lane: squares a phasor, then one root bit per stage (floor(256*|z|)).
// Depends on dsdr_pkg.
`timescale 1ns / 1ps

module dsdr_sqrt import dsdr_pkg::*; (
    input  logic                   aclk,
    input  logic                   adv,
    input  logic signed [PH_W-1:0] re,
    input  logic signed [PH_W-1:0] im,
    output logic [ROOT_W-1:0]      root
);

    logic signed [2*PH_W-1:0] re_sq;
    logic signed [2*PH_W-1:0] im_sq;
    logic [SQ_W-1:0]          sq_next;
    logic [RAD_W-1:0]         rad_reg;

    logic [RAD_W-1:0]  v_in    [ROOT_W];
    logic [REM_W-1:0]  rem_in  [ROOT_W];
    logic [ROOT_W-1:0] rt_in   [ROOT_W];
    logic [RAD_W-1:0]  v_next  [ROOT_W];
    logic [REM_W-1:0]  rem_next[ROOT_W];
    logic [ROOT_W-1:0] rt_next [ROOT_W];
    logic [RAD_W-1:0]  v_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg [ROOT_W];
    logic [ROOT_W-1:0] rt_reg  [ROOT_W];

    assign re_sq   = re * re;
    assign im_sq   = im * im;
    assign sq_next = SQ_W'(unsigned'(re_sq)) + SQ_W'(unsigned'(im_sq));

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg <= {sq_next, 16'b0};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign v_in[k]   = rad_reg;
            assign rem_in[k] = '0;
            assign rt_in[k]  = '0;
        end else begin : g_rest
            assign v_in[k]   = v_reg[k-1];
            assign rem_in[k] = rem_reg[k-1];
            assign rt_in[k]  = rt_reg[k-1];
        end

        assign rem_sh      = {rem_in[k], v_in[k][RAD_W-1 -: 2]};
        assign trial       = (REM_W+2)'({rt_in[k], 2'b01});
        assign ge          = (rem_sh >= trial);
        assign rem_next[k] = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        assign rt_next[k]  = {rt_in[k][ROOT_W-2:0], ge};
        assign v_next[k]   = {v_in[k][RAD_W-3:0], 2'b00};

        always_ff @(posedge aclk) begin
            if (adv) begin
                v_reg[k]   <= v_next[k];
                rem_reg[k] <= rem_next[k];
                rt_reg[k]  <= rt_next[k];
            end
        end
    end

    assign root = rt_reg[ROOT_W-1];

endmodule

>>> rtl/dsdr_div.sv
// Pipelined restoring divider, one quotient bit per stage, divisor carried along.
// Depends on dsdr_pkg.
`timescale 1ns / 1ps

module dsdr_div import dsdr_pkg::*; (
    input  logic             aclk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] n_in    [NUM_W];
    logic [DEN_W-1:0] r_in    [NUM_W];
    logic [DEN_W-1:0] d_in    [NUM_W];
    logic [NUM_W-1:0] n_next  [NUM_W];
    logic [DEN_W-1:0] r_next  [NUM_W];
    logic [NUM_W-1:0] n_reg   [NUM_W];
    logic [DEN_W-1:0] r_reg   [NUM_W];
    logic [DEN_W-1:0] d_reg   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0] t;
        logic           ge;

        if (k == 0) begin : g_first
            assign n_in[k] = num;
            assign r_in[k] = '0;
            assign d_in[k] = den;
        end else begin : g_rest
            assign n_in[k] = n_reg[k-1];
            assign r_in[k] = r_reg[k-1];
            assign d_in[k] = d_reg[k-1];
        end

        assign t         = {r_in[k], n_in[k][NUM_W-1]};
        assign ge        = (t >= {1'b0, d_in[k]});
        assign r_next[k] = ge ? DEN_W'(t - {1'b0, d_in[k]}) : DEN_W'(t);
        assign n_next[k] = {n_in[k][NUM_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (adv) begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
                d_reg[k] <= d_in[k];
            end
        end
    end

    assign quo = n_reg[NUM_W-1];

endmodule

>>> rtl/dsdr_char.sv
// Characteristic breakpoint sequencer: recomputes the three breaks after reset or a write,
// with a shared multiplier pair and a bit-serial divider. Depends on dsdr_pkg.
`timescale 1ns / 1ps

module dsdr_char import dsdr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  cfg_t cfg,
    output brk_t brk
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;

    localparam logic [1:0] JOB_BRK1 = 2'd0;
    localparam logic [1:0] JOB_BRK2 = 2'd1;
    localparam logic [1:0] JOB_BRK3 = 2'd2;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         job_reg, job_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        pa_reg, pa_next;
    logic [31:0]        pb_reg, pb_next;
    logic signed [16:0] den_reg, den_next;
    logic [15:0]        off_reg, off_next;
    logic               zero_reg, zero_next;
    logic               neg_reg, neg_next;
    logic [31:0]        dvd_reg, dvd_next;
    logic [15:0]        rem_reg, rem_next;
    logic [15:0]        dsr_reg, dsr_next;
    logic signed [31:0] brk1_reg, brk1_next;
    logic signed [31:0] brk2_reg, brk2_next;
    logic signed [31:0] brk3_reg, brk3_next;

    logic [15:0]        ma1, ma2, mb1, mb2;
    logic signed [33:0] num;
    logic signed [33:0] num_abs;
    logic signed [16:0] den_abs;
    logic [16:0]        t;
    logic               ge;
    logic signed [34:0] q_s;
    logic signed [34:0] q_sum;
    logic signed [31:0] q_sat;

    always_comb begin
        ma1 = cfg.pickup_low;
        ma2 = SLOPE_DEN;
        mb1 = '0;
        mb2 = '0;
        case (job_reg)
            JOB_BRK2: begin
                ma1 = cfg.slope_low_pct;
                ma2 = cfg.base_low;
                mb1 = cfg.slope_high_pct;
                mb2 = cfg.base_high;
            end
            JOB_BRK3: begin
                ma1 = cfg.pickup_high;
            end
            default: begin
            end
        endcase
    end

    assign num     = $signed({2'b00, pa_reg}) - $signed({2'b00, pb_reg});
    assign num_abs = num[33] ? -num : num;
    assign den_abs = den_reg[16] ? -den_reg : den_reg;
    assign t       = {rem_reg, dvd_reg[31]};
    assign ge      = (t >= {1'b0, dsr_reg});

    always_comb begin
        q_s = $signed({3'b000, dvd_reg});
        if (neg_reg) begin
            q_s = -($signed({3'b000, dvd_reg}) + 35'(rem_reg != '0));
        end
        q_sum = q_s + $signed({19'b0, off_reg});
        if (zero_reg || q_sum > 35'(BRK_MAX)) begin
            q_sat = BRK_MAX;
        end else if (q_sum < 35'(BRK_MIN)) begin
            q_sat = BRK_MIN;
        end else begin
            q_sat = q_sum[31:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        den_next   = den_reg;
        off_next   = off_reg;
        zero_next  = zero_reg;
        neg_next   = neg_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        brk1_next  = brk1_reg;
        brk2_next  = brk2_reg;
        brk3_next  = brk3_reg;
        case (state_reg)
            ST_MUL: begin
                pa_next = 32'(ma1) * 32'(ma2);
                pb_next = 32'(mb1) * 32'(mb2);
                case (job_reg)
                    JOB_BRK2: begin
                        den_next  = $signed({1'b0, cfg.slope_low_pct})
                                  - $signed({1'b0, cfg.slope_high_pct});
                        off_next  = '0;
                        zero_next = (cfg.slope_low_pct == cfg.slope_high_pct);
                    end
                    JOB_BRK3: begin
                        den_next  = $signed({1'b0, cfg.slope_high_pct});
                        off_next  = cfg.base_high;
                        zero_next = (cfg.slope_high_pct == '0);
                    end
                    default: begin
                        den_next  = $signed({1'b0, cfg.slope_low_pct});
                        off_next  = cfg.base_low;
                        zero_next = (cfg.slope_low_pct == '0);
                    end
                endcase
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                dvd_next   = num_abs[31:0];
                dsr_next   = den_abs[15:0];
                rem_next   = '0;
                neg_next   = num[33] ^ den_reg[16];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = ge ? 16'(t - {1'b0, dsr_reg}) : t[15:0];
                dvd_next = {dvd_reg[30:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == '1) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                case (job_reg)
                    JOB_BRK2: brk2_next = q_sat;
                    JOB_BRK3: brk3_next = q_sat;
                    default:  brk1_next = q_sat;
                endcase
                if (job_reg == JOB_BRK3) begin
                    state_next = ST_IDLE;
                end else begin
                    job_next   = job_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we) begin
            state_next = ST_MUL;
            job_next   = JOB_BRK1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_MUL;
            job_reg   <= JOB_BRK1;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        den_reg  <= den_next;
        off_reg  <= off_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        brk1_reg <= brk1_next;
        brk2_reg <= brk2_next;
        brk3_reg <= brk3_next;
    end

    assign brk.busy = (state_reg != ST_IDLE);
    assign brk.brk1 = brk1_reg;
    assign brk.brk2 = brk2_reg;
    assign brk.brk3 = brk3_reg;

endmodule

>>> rtl/dsdr_zone.sv
// Zone test: saturation and slope products in one stage, zone select into the result register.
// Depends on dsdr_pkg.
`timescale 1ns / 1ps

module dsdr_zone import dsdr_pkg::*; (
    input  logic             aclk,
    input  logic             adv,
    input  logic [NUM_W-1:0] rs_q,
    input  logic [NUM_W-1:0] op_q,
    input  cfg_t             cfg,
    input  brk_t             brk,
    output out_item_t        res
);

    logic [15:0]        ir, io;
    logic signed [31:0] irx;
    logic signed [16:0] s1x, s2x, d1, d2;

    logic [15:0]        ir_reg, io_reg;
    logic               lt1_reg, gt1_reg, lt2_reg, gt2_reg, lt3_reg, gt3_reg;
    logic               op1_reg, op2_reg;
    logic [30:0]        lhs_reg, lhs_next;
    logic signed [33:0] rhs1_reg, rhs1_next;
    logic signed [33:0] rhs2_reg, rhs2_next;

    logic signed [33:0] lhs_s;
    logic [2:0]         zone_next;
    out_item_t          res_reg, res_next;

    assign ir  = (|rs_q[NUM_W-1:16]) ? 16'hFFFF : rs_q[15:0];
    assign io  = (|op_q[NUM_W-1:16]) ? 16'hFFFF : op_q[15:0];
    assign irx = $signed({16'b0, ir});
    assign s1x = $signed({1'b0, cfg.slope_low_pct});
    assign s2x = $signed({1'b0, cfg.slope_high_pct});
    assign d1  = $signed({1'b0, ir}) - $signed({1'b0, cfg.base_low});
    assign d2  = $signed({1'b0, ir}) - $signed({1'b0, cfg.base_high});

    assign lhs_next  = 31'(io) * 31'(SLOPE_DEN);
    assign rhs1_next = s1x * d1;
    assign rhs2_next = s2x * d2;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ir_reg   <= ir;
            io_reg   <= io;
            lt1_reg  <= (irx < brk.brk1);
            gt1_reg  <= (irx > brk.brk1);
            lt2_reg  <= (irx < brk.brk2);
            gt2_reg  <= (irx > brk.brk2);
            lt3_reg  <= (irx < brk.brk3);
            gt3_reg  <= (irx > brk.brk3);
            op1_reg  <= (io > cfg.pickup_low);
            op2_reg  <= (io > cfg.pickup_high);
            lhs_reg  <= lhs_next;
            rhs1_reg <= rhs1_next;
            rhs2_reg <= rhs2_next;
        end
    end

    assign lhs_s = $signed({3'b000, lhs_reg});

    always_comb begin
        zone_next = ZONE_NONE;
        if (lt1_reg && op1_reg) begin
            zone_next = ZONE_PICKUP_L;
        end
        if (lt2_reg && gt1_reg && (lhs_s > rhs1_reg)) begin
            zone_next = ZONE_SLOPE_1;
        end
        if (lt3_reg && gt2_reg && (lhs_s > rhs2_reg)) begin
            zone_next = ZONE_SLOPE_2;
        end
        if (gt3_reg && op2_reg) begin
            zone_next = ZONE_PICKUP_H;
        end
        res_next.trip      = (zone_next != ZONE_NONE);
        res_next.zone      = zone_next;
        res_next.restraint = ir_reg;
        res_next.operate   = io_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/dual_slope_differential_relay.sv
// Dual-slope percentage differential relay (87) top level: config registers, magnitude lanes,
// dividers, zone test and valid pipeline. Depends on dsdr_pkg and all dsdr_* modules.
//
//   port group   dir   handshake          payload
//   s_*          in    s_valid/s_ready    in_item_t  (two terminal phasors)
//   m_*          out   m_valid/m_ready    out_item_t (trip, zone, restraint, operate)
//   cfg_*        in    cfg_we             cfg_index, cfg_data
//
// One request per cycle while s_ready is high, through the square, 25 root stages, sum, 26 divide
// stages and two zone stages. The breakpoint sequencer runs after reset and after each write;
// s_ready stays low meanwhile. A stall on m_ready freezes the whole pipeline.
`timescale 1ns / 1ps

module dual_slope_differential_relay import dsdr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t             cfg_reg, cfg_next;
    brk_t             brk;
    logic             adv;
    logic [LAT-1:0]   vld_reg, vld_next;

    logic signed [PH_W-1:0] r1, i1, r2, i2, rs_sum, is_sum;
    logic [ROOT_W-1:0]      m1, m2, m12;
    logic [NUM_W-1:0]       rs_num_reg, op_num_reg, rs_q, op_q;
    logic [DEN_W-1:0]       dsr_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_NOMINAL:     cfg_next.nominal_current = cfg_data;
                REG_PICKUP_LOW:  cfg_next.pickup_low      = cfg_data;
                REG_PICKUP_HIGH: cfg_next.pickup_high     = cfg_data;
                REG_SLOPE_LOW:   cfg_next.slope_low_pct   = cfg_data;
                REG_SLOPE_HIGH:  cfg_next.slope_high_pct  = cfg_data;
                REG_BASE_LOW:    cfg_next.base_low        = cfg_data;
                REG_BASE_HIGH:   cfg_next.base_high       = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dsdr_char u_char (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .cfg     (cfg_reg),
        .brk     (brk)
    );

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv && !brk.busy;
    assign m_valid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], s_valid && s_ready};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    assign r1     = PH_W'(s_data.first_real);
    assign i1     = PH_W'(s_data.first_imag);
    assign r2     = PH_W'(s_data.second_real);
    assign i2     = PH_W'(s_data.second_imag);
    assign rs_sum = r1 + r2;
    assign is_sum = i1 + i2;

    dsdr_sqrt u_mag1 (.aclk(aclk), .adv(adv), .re(r1), .im(i1), .root(m1));
    dsdr_sqrt u_mag2 (.aclk(aclk), .adv(adv), .re(r2), .im(i2), .root(m2));
    dsdr_sqrt u_mag12 (.aclk(aclk), .adv(adv), .re(rs_sum), .im(is_sum), .root(m12));

    always_ff @(posedge aclk) begin
        if (adv) begin
            rs_num_reg <= NUM_W'(m1) + NUM_W'(m2);
            op_num_reg <= NUM_W'(m12);
            dsr_reg    <= (cfg_reg.nominal_current == '0) ? DEN_W'(1) : cfg_reg.nominal_current;
        end
    end

    dsdr_div u_div_rs (.aclk(aclk), .adv(adv), .num(rs_num_reg), .den(dsr_reg), .quo(rs_q));
    dsdr_div u_div_op (.aclk(aclk), .adv(adv), .num(op_num_reg), .den(dsr_reg), .quo(op_q));

    dsdr_zone u_zone (
        .aclk (aclk),
        .adv  (adv),
        .rs_q (rs_q),
        .op_q (op_q),
        .cfg  (cfg_reg),
        .brk  (brk),
        .res  (m_data)
    );

endmodule

>>> tb/sv/dual_slope_differential_relay_tb.sv
// Testbench for dual_slope_differential_relay: table-driven and random phasor pairs
// checked against an in-bench relay predictor. Depends on dsdr_pkg and the RTL.
`timescale 1ns / 1ps

module dual_slope_differential_relay_tb;
    import dsdr_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_item_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_item_t        m_data;
    logic             cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NOMINAL;
    logic [15:0]      cfg_data = '0;

    dual_slope_differential_relay uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        in_item_t  req;
        bit        known;
        out_item_t res;
    } row_t;

    cfg_t      relay_cfg;
    longint    brk [3];
    out_item_t pending_results [$];
    int        errors = 0;
    int        sent = 0;
    int        received = 0;
    int        burst_left = 0;
    int        rx_period = 1;
    int        rx_open = 1;
    int        rx_cyc = 0;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        q = n / d;
        if ((n % d != 0) && (n < 0)) q = q - 1;
        return q;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void update_breaks();
        longint s1, s2, b1, b2;
        s1 = relay_cfg.slope_low_pct;
        s2 = relay_cfg.slope_high_pct;
        b1 = relay_cfg.base_low;
        b2 = relay_cfg.base_high;
        brk[0] = (s1 == 0) ? 64'sd2147483647 :
            clamp32(floor_div(longint'(relay_cfg.pickup_low) * 25600, s1) + b1);
        brk[1] = (s1 == s2) ? 64'sd2147483647 : clamp32(floor_div(s1 * b1 - s2 * b2, s1 - s2));
        brk[2] = (s2 == 0) ? 64'sd2147483647 :
            clamp32(floor_div(longint'(relay_cfg.pickup_high) * 25600, s2) + b2);
    endfunction

    function automatic longint unsigned root_q8(longint re, longint im);
        longint unsigned v, r, b;
        v = longint'(re * re + im * im) << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic out_item_t relay_response(in_item_t x);
        out_item_t o;
        longint r1, i1, r2, i2, dv, rs, op;
        r1 = x.first_real;
        i1 = x.first_imag;
        r2 = x.second_real;
        i2 = x.second_imag;
        dv = (relay_cfg.nominal_current == 0) ? 1 : relay_cfg.nominal_current;
        rs = longint'(root_q8(r1, i1) + root_q8(r2, i2)) / dv;
        op = longint'(root_q8(r1 + r2, i1 + i2)) / dv;
        if (rs > 65535) rs = 65535;
        if (op > 65535) op = 65535;
        o.zone = ZONE_NONE;
        if (rs < brk[0] && op > relay_cfg.pickup_low) o.zone = ZONE_PICKUP_L;
        if (brk[1] > rs && rs > brk[0] &&
            op * 25600 > longint'(relay_cfg.slope_low_pct) *
                         (rs - longint'(relay_cfg.base_low)))
            o.zone = ZONE_SLOPE_1;
        if (brk[2] > rs && rs > brk[1] &&
            op * 25600 > longint'(relay_cfg.slope_high_pct) *
                         (rs - longint'(relay_cfg.base_high)))
            o.zone = ZONE_SLOPE_2;
        if (rs > brk[2] && op > relay_cfg.pickup_high) o.zone = ZONE_PICKUP_H;
        o.trip = (o.zone != ZONE_NONE);
        o.restraint = rs[15:0];
        o.operate = op[15:0];
        return o;
    endfunction

    // receiver: check accepted results, then stall on a period/duty pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            received++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, m_data);
            end else begin
                out_item_t e;
                e = pending_results.pop_front();
                if (m_data.trip !== e.trip) begin
                    errors++;
                    $display("%0t: trip exp %0d got %0d", $time, e.trip, m_data.trip);
                end
                if (m_data.zone !== e.zone) begin
                    errors++;
                    $display("%0t: zone exp %0d got %0d", $time, e.zone, m_data.zone);
                end
                if (m_data.restraint !== e.restraint) begin
                    errors++;
                    $display("%0t: restraint exp %0d got %0d", $time, e.restraint,
                             m_data.restraint);
                end
                if (m_data.operate !== e.operate) begin
                    errors++;
                    $display("%0t: operate exp %0d got %0d", $time, e.operate, m_data.operate);
                end
            end
        end
        rx_cyc++;
        m_ready <= (rx_cyc % rx_period) < rx_open;
    end

    task automatic send_request(in_item_t x, bit known, out_item_t res);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(known ? res : relay_response(x));
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LAT + 5) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NOMINAL:     relay_cfg.nominal_current = val;
            REG_PICKUP_LOW:  relay_cfg.pickup_low = val;
            REG_PICKUP_HIGH: relay_cfg.pickup_high = val;
            REG_SLOPE_LOW:   relay_cfg.slope_low_pct = val;
            REG_SLOPE_HIGH:  relay_cfg.slope_high_pct = val;
            REG_BASE_LOW:    relay_cfg.base_low = val;
            REG_BASE_HIGH:   relay_cfg.base_high = val;
            default: ;
        endcase
        update_breaks();
        @(posedge aclk);
    endtask

    task automatic load_settings(logic [15:0] nom, logic [15:0] pl, logic [15:0] ph,
                                 logic [15:0] s1, logic [15:0] s2,
                                 logic [15:0] b1, logic [15:0] b2);
        drain();
        write_reg(REG_NOMINAL, nom);
        write_reg(REG_PICKUP_LOW, pl);
        write_reg(REG_PICKUP_HIGH, ph);
        write_reg(REG_SLOPE_LOW, s1);
        write_reg(REG_SLOPE_HIGH, s2);
        write_reg(REG_BASE_LOW, b1);
        write_reg(REG_BASE_HIGH, b2);
    endtask

    function automatic logic [15:0] scaled_value();
        logic signed [15:0] v;
        v = 16'($urandom);
        return v >>> $urandom_range(0, 15);
    endfunction

    function automatic in_item_t random_phasors();
        in_item_t x;
        x.first_real = scaled_value();
        x.first_imag = scaled_value();
        case ($urandom_range(0, 3))
            0: begin
                x.second_real = 16'($urandom);
                x.second_imag = 16'($urandom);
            end
            1: begin
                // through-fault: terminals nearly cancel
                x.second_real = -x.first_real + (scaled_value() >>> 6);
                x.second_imag = -x.first_imag + (scaled_value() >>> 6);
            end
            default: begin
                x.second_real = scaled_value();
                x.second_imag = scaled_value();
            end
        endcase
        return x;
    endfunction

    task automatic random_phase(int n);
        in_item_t x;
        rx_period = $urandom_range(1, 9);
        rx_open = $urandom_range(1, rx_period);
        for (int i = 0; i < n; i++) begin
            x = random_phasors();
            send_request(x, 1'b0, '0);
            if (i == n / 2 && $urandom_range(0, 1)) drain();
        end
    endtask

    row_t directed [] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{1'b0, ZONE_NONE, 16'd0, 16'd0}},
        '{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
          '{1'b1, ZONE_PICKUP_H, 16'd32767, 16'd32767}},
        '{'{16'sd32767, 16'sd0, -16'sd32767, 16'sd0}, 1'b1,
          '{1'b0, ZONE_NONE, 16'd65534, 16'd0}},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b1,
          '{1'b1, ZONE_PICKUP_H, 16'd65535, 16'd65535}},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
        '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, 1'b0, '0},
        '{'{16'sd100, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
        '{'{16'sd300, 16'sd0, -16'sd250, 16'sd0}, 1'b0, '0},
        '{'{16'sd500, 16'sd0, -16'sd200, 16'sd0}, 1'b0, '0},
        '{'{16'sd1500, 16'sd0, -16'sd700, 16'sd0}, 1'b0, '0},
        '{'{16'sd3000, 16'sd0, -16'sd800, 16'sd0}, 1'b0, '0},
        '{'{16'sd0, 16'sd2000, 16'sd0, 16'sd1000}, 1'b0, '0},
        '{'{-16'sd1, -16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
        '{'{16'sd0, -16'sd32768, 16'sd0, -16'sd32768}, 1'b0, '0}
    };

    initial begin
        relay_cfg = CFG_RESET;
        update_breaks();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) send_request(directed[i].req, directed[i].known, directed[i].res);
        random_phase(250);
        // extremes: unit divisor, zero and full pickups, zero slopes, top bases
        load_settings(16'd1, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535);
        random_phase(180);
        load_settings(16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd0);
        random_phase(180);
        // equal slopes
        load_settings(16'd64, 16'd40, 16'd1200, 16'd9000, 16'd9000, 16'd100, 16'd300);
        random_phase(180);
        // zero divisor falls back to one; index 7 write must be ignored
        load_settings(16'd0, 16'd500, 16'd30000, 16'd3000, 16'd25000, 16'd200, 16'd1500);
        write_reg(3'd7, 16'hFFFF);
        random_phase(180);
        for (int p = 0; p < 6; p++) begin
            load_settings(16'($urandom_range(1, 2048)), 16'($urandom_range(0, 2000)),
                          16'($urandom_range(0, 40000)), 16'($urandom_range(0, 30000)),
                          16'($urandom_range(0, 30000)), 16'($urandom_range(0, 3000)),
                          16'($urandom_range(0, 3000)));
            random_phase(p == 5 ? 136 : 140);
        end
        load_settings(CFG_RESET.nominal_current, CFG_RESET.pickup_low, CFG_RESET.pickup_high,
                      CFG_RESET.slope_low_pct, CFG_RESET.slope_high_pct,
                      CFG_RESET.base_low, CFG_RESET.base_high);
        random_phase(150);
        drain();
        $display("Sent %0d requests, %0d results checked, over 12 register settings", sent,
                 received);
        $display("including unit/zero divisor, zero and equal slopes, saturating magnitudes");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
